/* src/dta_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the detection track associator.
// Used by dta_ctrl, dta_datapath and detection_track_associator_unit; no dependencies.
package dta_pkg;

    localparam int CLASS_W    = 8;
    localparam int SLOT_W     = 6;
    localparam int CONF_W     = 7;
    localparam int HITS_W     = 4;
    localparam int HIT_MOD    = 10;
    localparam int CONF_SCALE = 10;
    localparam int NEW_CONF   = 1;
    localparam int NEW_HITS   = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FETCH,
        ST_WRITE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // latch the detection, clear scan index and best match
        logic issue;     // read the entry at the scan index
        logic fetch;     // read the best entry for its hit count
        logic commit;    // write the entry back and load the result register
    } t_dta_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;     // table holds no entry
        logic scan_last; // scan index points at the last stored entry
        logic pipe_busy; // overlap pipeline still holds reads
        logic out_free;  // result register can take a new result
    } t_dta_status;

endpackage

/* src/detection_track_associator_unit.sv */
`timescale 1ns / 1ps
// Top level of the detection track associator: greedy maximum-overlap association.
// Depends on dta_pkg, dta_ctrl and dta_datapath.
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall    i_box_x, i_box_y, i_box_w, i_box_h,
//                                                  i_class_label
//  result    out        o_out_valid / i_out_stall  o_slot, o_matched, o_dropped,
//                                                  o_confidence
//
// A detection is handled in order: a scan with one table read per stored entry (skipped
// when the table is empty), a drain of the overlap pipeline, a fetch of the best entry and
// a write-back; the next detection is taken only after the write-back.
// Reset (i_rst_n low, synchronous) clears the entry count and control state, not the table. A stalled result waits in
// the result register while the next detection is accepted; write-back waits for it.
module detection_track_associator_unit
    import dta_pkg::*;
#(
    parameter int MAX_OBJECTS = 64,
    parameter int COORD_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Detection channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_box_x,
    input  logic [COORD_BITS-1:0] i_box_y,
    input  logic [COORD_BITS-1:0] i_box_w,
    input  logic [COORD_BITS-1:0] i_box_h,
    input  logic [CLASS_W-1:0]    i_class_label,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_matched,
    output logic                  o_dropped,
    output logic [CONF_W-1:0]     o_confidence
);

    t_dta_cmd    cmd;
    t_dta_status status;

    // Sequence each transaction: capture, scan, drain, fetch, write back
    dta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Hold the table, compute overlaps, track the best entry, register the result
    dta_datapath #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_box_x       (i_box_x),
        .i_box_y       (i_box_y),
        .i_box_w       (i_box_w),
        .i_box_h       (i_box_h),
        .i_class_label (i_class_label),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_slot        (o_slot),
        .o_matched     (o_matched),
        .o_dropped     (o_dropped),
        .o_confidence  (o_confidence)
    );

endmodule

/* src/dta_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the detection track associator.
// Depends on dta_pkg; drives dta_datapath through t_dta_cmd.
module dta_ctrl
    import dta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_dta_status i_status,
    output t_dta_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = i_status.empty ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_WRITE;
            end
            ST_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* src/dta_datapath.sv */
`timescale 1ns / 1ps
// Datapath: object table memory, overlap pipeline, best-match tracking, result register.
// Depends on dta_pkg; commanded by dta_ctrl.
module dta_datapath
    import dta_pkg::*;
#(
    parameter int MAX_OBJECTS = 64,
    parameter int COORD_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dta_cmd              i_cmd,
    output t_dta_status           o_status,
    input  logic [COORD_BITS-1:0] i_box_x,
    input  logic [COORD_BITS-1:0] i_box_y,
    input  logic [COORD_BITS-1:0] i_box_w,
    input  logic [COORD_BITS-1:0] i_box_h,
    input  logic [CLASS_W-1:0]    i_class_label,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_matched,
    output logic                  o_dropped,
    output logic [CONF_W-1:0]     o_confidence
);

    localparam int IDX_W   = $clog2(MAX_OBJECTS);
    localparam int CNT_W   = $clog2(MAX_OBJECTS + 1);
    localparam int SUM_W   = COORD_BITS + 1;
    localparam int AREA_W  = 2 * SUM_W;
    localparam int ENTRY_W = 4 * COORD_BITS + CLASS_W + HITS_W;

    // Detection under work
    logic [COORD_BITS-1:0] r_box_x, r_box_y, r_box_w, r_box_h;
    logic [CLASS_W-1:0]    r_class;

    logic [CNT_W-1:0]      r_count;
    logic [IDX_W-1:0]      r_scan_idx;

    // Table memory
    logic [ENTRY_W-1:0]    mem [MAX_OBJECTS];
    logic [ENTRY_W-1:0]    r_rd_data;
    logic                  r_rd_valid;
    logic [IDX_W-1:0]      r_rd_idx;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [ENTRY_W-1:0]    wr_data;

    // Overlap pipeline
    logic [COORD_BITS-1:0] e_x, e_y, e_w, e_h;
    logic [HITS_W-1:0]     e_hits;
    logic [SUM_W-1:0]      a_x1, a_y1, b_x1, b_y1, x0, y0, x1, y1, dx, dy;
    logic [SUM_W-1:0]      r_dx, r_dy;
    logic                  r_s1_valid;
    logic [IDX_W-1:0]      r_s1_idx;
    logic [AREA_W-1:0]     r_area;
    logic                  r_s2_valid;
    logic [IDX_W-1:0]      r_s2_idx;

    // Best match
    logic [AREA_W-1:0]     r_best_area;
    logic [IDX_W-1:0]      r_best_idx;
    logic                  r_found;

    // Write-back
    logic                  full;
    logic [HITS_W-1:0]     hits_next;
    logic [CONF_W-1:0]     conf_hit;

    logic                  r_out_valid;
    logic [SLOT_W-1:0]     r_slot;
    logic                  r_matched;
    logic                  r_dropped;
    logic [CONF_W-1:0]     r_conf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_box_x <= i_box_x;
            r_box_y <= i_box_y;
            r_box_w <= i_box_w;
            r_box_h <= i_box_h;
            r_class <= i_class_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
        end else if (i_cmd.capture) begin
            r_scan_idx <= '0;
        end else if (i_cmd.issue) begin
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
    end

    assign full = (r_count == CNT_W'(MAX_OBJECTS));

    // Memory: one read and one write port, read data registered and held between reads
    assign rd_addr = i_cmd.fetch ? r_best_idx : r_scan_idx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.issue || i_cmd.fetch) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign {e_x, e_y, e_w, e_h} = r_rd_data[ENTRY_W-1 -: 4*COORD_BITS];
    assign e_hits               = r_rd_data[HITS_W-1:0];

    // Stage 1: intersection extents
    assign a_x1 = SUM_W'(r_box_x) + SUM_W'(r_box_w);
    assign a_y1 = SUM_W'(r_box_y) + SUM_W'(r_box_h);
    assign b_x1 = SUM_W'(e_x) + SUM_W'(e_w);
    assign b_y1 = SUM_W'(e_y) + SUM_W'(e_h);
    assign x0   = (r_box_x > e_x) ? SUM_W'(r_box_x) : SUM_W'(e_x);
    assign y0   = (r_box_y > e_y) ? SUM_W'(r_box_y) : SUM_W'(e_y);
    assign x1   = (a_x1 < b_x1) ? a_x1 : b_x1;
    assign y1   = (a_y1 < b_y1) ? a_y1 : b_y1;
    assign dx   = (x1 > x0) ? (x1 - x0) : '0;
    assign dy   = (y1 > y0) ? (y1 - y0) : '0;

    always_ff @(posedge i_clk) begin
        r_dx     <= dx;
        r_dy     <= dy;
        r_s1_idx <= r_rd_idx;
        r_area   <= AREA_W'(r_dx) * AREA_W'(r_dy);
        r_s2_idx <= r_s1_idx;
        r_rd_idx <= r_scan_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.issue;
            r_s1_valid <= r_rd_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    // Stage 3: keep the first strict maximum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_best_area <= '0;
            r_best_idx  <= '0;
        end else if (i_cmd.capture) begin
            r_found     <= 1'b0;
            r_best_area <= '0;
            r_best_idx  <= '0;
        end else if (r_s2_valid && (r_area > r_best_area)) begin
            r_found     <= 1'b1;
            r_best_area <= r_area;
            r_best_idx  <= r_s2_idx;
        end
    end

    // Write-back: stored hit count is already reduced mod 10
    assign hits_next = (e_hits >= HITS_W'(HIT_MOD - 1)) ? '0 : e_hits + HITS_W'(1);
    assign conf_hit  = CONF_W'(e_hits) * CONF_W'(CONF_SCALE);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_best_idx;
        wr_data = {r_box_x, r_box_y, r_box_w, r_box_h, r_class, hits_next};
        if (i_cmd.commit) begin
            if (r_found) begin
                wr_en = 1'b1;
            end else if (!full) begin
                wr_en   = 1'b1;
                wr_addr = r_count[IDX_W-1:0];
                wr_data = {r_box_x, r_box_y, r_box_w, r_box_h, r_class, HITS_W'(NEW_HITS)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit && !r_found && !full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_found) begin
                r_slot    <= SLOT_W'(r_best_idx);
                r_matched <= 1'b1;
                r_dropped <= 1'b0;
                r_conf    <= conf_hit;
            end else if (full) begin
                r_slot    <= '0;
                r_matched <= 1'b0;
                r_dropped <= 1'b1;
                r_conf    <= '0;
            end else begin
                r_slot    <= SLOT_W'(r_count[IDX_W-1:0]);
                r_matched <= 1'b0;
                r_dropped <= 1'b0;
                r_conf    <= CONF_W'(NEW_CONF);
            end
        end
    end

    assign o_status.empty     = (r_count == '0);
    assign o_status.scan_last = ((CNT_W'(r_scan_idx) + CNT_W'(1)) == r_count);
    assign o_status.pipe_busy = r_rd_valid | r_s1_valid | r_s2_valid;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_slot;
    assign o_matched    = r_matched;
    assign o_dropped    = r_dropped;
    assign o_confidence = r_conf;

endmodule
